@@ rtl/core/grcs_pkg.sv @@
// grcs_pkg: shared constants and types for the grid ray collision search unit
// no dependencies
package grcs_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MASK_BITS  = 8;

  localparam int CX_W   = $clog2(MAX_WIDTH);
  localparam int CY_W   = $clog2(MAX_HEIGHT);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  // signed cell coordinate of the ray, wide enough for a full walk
  localparam int CELL_W = 10;
  localparam int GRID_W = 7;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

  localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

  typedef logic [MASK_BITS-1:0] mask_t;

  // what the shared divider result is used for
  typedef enum logic [1:0] {
    DIV_STEP_X = 2'd0,
    DIV_STEP_Y = 2'd1,
    DIV_HIT_X  = 2'd2,
    DIV_HIT_Y  = 2'd3
  } div_sel_e;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7FFF;
    if (v < -18'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

@@ rtl/core/grid_ray_collision_search_unit.sv @@
// grid_ray_collision_search_unit: cell mask store plus dda ray walker
// uses grcs_pkg; single 4096 x 8 synchronous mask memory
// a write item is taken while idle. a trace runs a bit-serial square root, then
// the step divisions (skipped for a zero component), the first boundary
// distances, one mask read per grid step and, on a hit, the bit-serial
// divisions for the hit point
// one item at a time; a result waits in the output register while the next
// item is taken. after reset a clearing pass zeroes the mask store
module grid_ray_collision_search_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [5:0]                     cell_x_i,
  input  logic [5:0]                     cell_y_i,
  input  logic [7:0]                     cell_mask_i,
  input  logic signed [15:0]             start_x_i,
  input  logic signed [15:0]             start_y_i,
  input  logic signed [15:0]             traj_x_i,
  input  logic signed [15:0]             traj_y_i,
  input  logic [7:0]                     test_mask_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o,
  output logic signed [15:0]             hit_x_o,
  output logic signed [15:0]             hit_y_o,
  output logic                           vertical_hit_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [grcs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [grcs_pkg::GRID_W-1:0]    cfg_data_i
);
  import grcs_pkg::*;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SQX    = 4'd2;
  localparam logic [3:0] S_SQY    = 4'd3;
  localparam logic [3:0] S_SQRT   = 4'd4;
  localparam logic [3:0] S_PREPX  = 4'd5;
  localparam logic [3:0] S_PREPY  = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_DIVEND = 4'd8;
  localparam logic [3:0] S_FBX    = 4'd9;
  localparam logic [3:0] S_FBY    = 4'd10;
  localparam logic [3:0] S_STEP   = 4'd11;
  localparam logic [3:0] S_TEST   = 4'd12;
  localparam logic [3:0] S_ALX    = 4'd13;
  localparam logic [3:0] S_ALY    = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  logic [3:0] state_q, state_d;

  mask_t mem [DEPTH];
  mask_t rdata_q;

  logic [ADDR_W:0] clr_cnt_q;
  logic [GRID_W-1:0] gw_q, gh_q;

  // latched trace request
  logic signed [15:0] sx_q, sy_q, tx_q, ty_q;
  logic [15:0] ax_q, ay_q;
  mask_t tmask_q;

  logic [31:0] acc_q;
  logic [47:0] rad_q;
  logic [25:0] srem_q;
  logic [23:0] len_q;
  logic [5:0]  cnt_q;

  logic [48:0] num_q;
  logic [23:0] dv_q;
  logic [23:0] drem_q;
  logic [31:0] quo_q;
  div_sel_e    sel_q;

  logic [31:0] stx_q, sty_q, px_q, py_q, dist_q;
  logic signed [CELL_W-1:0] cx_q, cy_q;
  logic vert_q, ingrid_q, over_q;

  logic hit_q;
  logic signed [15:0] hx_q, hy_q;

  logic out_valid_q, res_hit_q, res_vert_q;
  logic signed [15:0] res_x_q, res_y_q;

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o    = out_valid_q;
  assign hit_o          = res_hit_q;
  assign hit_x_o        = res_x_q;
  assign hit_y_o        = res_y_q;
  assign vertical_hit_o = res_vert_q;

  // ---------------- combinational datapath ----------------
  logic [25:0] sq_sh, sq_trial;
  logic [24:0] dv_sh;
  logic        dv_ge;
  logic [GRID_W-1:0] gw_eff, gh_eff;
  logic x_move;
  logic signed [CELL_W-1:0] nx, ny;
  logic [31:0] nd;
  logic [32:0] adv_sum;
  logic nin;
  logic [ADDR_W-1:0] rd_addr;
  logic [8:0]  fx_m;
  logic [40:0] fb_prod;
  logic [31:0] fb_val;
  logic signed [15:0] tc, sc;
  logic [15:0] amag;
  logic signed [17:0] hsum;
  logic mem_we;
  logic [ADDR_W-1:0] wr_addr;
  mask_t wr_data;
  logic out_free;

  always_comb begin
    sq_sh    = {srem_q[23:0], rad_q[47:46]};
    sq_trial = {len_q, 2'b01};
    dv_sh    = {drem_q, num_q[48]};
    dv_ge    = dv_sh >= {1'b0, dv_q};

    gw_eff = (gw_q > GRID_W'(MAX_WIDTH)) ? GRID_W'(MAX_WIDTH) : gw_q;
    gh_eff = (gh_q > GRID_W'(MAX_HEIGHT)) ? GRID_W'(MAX_HEIGHT) : gh_q;

    // tie goes along y
    x_move  = px_q < py_q;
    nx      = cx_q;
    ny      = cy_q;
    if (x_move) begin
      nx = tx_q[15] ? cx_q - CELL_W'(1) : cx_q + CELL_W'(1);
      nd = px_q;
      adv_sum = {1'b0, px_q} + {1'b0, stx_q};
    end else begin
      ny = ty_q[15] ? cy_q - CELL_W'(1) : cy_q + CELL_W'(1);
      nd = py_q;
      adv_sum = {1'b0, py_q} + {1'b0, sty_q};
    end
    nin = (nx >= 0) && (nx < $signed({{(CELL_W-GRID_W){1'b0}}, gw_eff}))
       && (ny >= 0) && (ny < $signed({{(CELL_W-GRID_W){1'b0}}, gh_eff}));
    rd_addr = ADDR_W'(ADDR_W'(ny[CY_W-1:0]) * ADDR_W'(MAX_WIDTH)
                      + ADDR_W'(nx[CX_W-1:0]));

    // first boundary distance for the axis under work
    if (state_q == S_FBX) begin
      tc = tx_q; sc = sx_q;
    end else begin
      tc = ty_q; sc = sy_q;
    end
    fx_m   = tc[15] ? {1'b0, sc[7:0]} : 9'd256 - {1'b0, sc[7:0]};
    if (state_q == S_FBX) begin
      fb_prod = 41'(9'(fx_m) * stx_q);
    end else begin
      fb_prod = 41'(9'(fx_m) * sty_q);
    end
    fb_val = (tc == 16'sd0 || fb_prod[40]) ? DIST_MAX : fb_prod[39:8];

    amag = (state_q == S_ALX) ? ax_q : ay_q;
    hsum = (sel_q == DIV_HIT_X) ? 18'(sx_q) : 18'(sy_q);
    if ((sel_q == DIV_HIT_X) ? tx_q[15] : ty_q[15])
      hsum = hsum - $signed({1'b0, quo_q[16:0]});
    else
      hsum = hsum + $signed({1'b0, quo_q[16:0]});

    mem_we  = 1'b0;
    wr_addr = clr_cnt_q[ADDR_W-1:0];
    wr_data = '0;
    if (state_q == S_CLR) begin
      mem_we = 1'b1;
    end else if (in_acc && !req_type_i && (32'(cell_x_i) < MAX_WIDTH)
                 && (32'(cell_y_i) < MAX_HEIGHT)) begin
      mem_we  = 1'b1;
      wr_addr = ADDR_W'(ADDR_W'(cell_y_i) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cell_x_i));
      wr_data = cell_mask_i[MASK_BITS-1:0];
    end

    out_free = !out_valid_q || !out_stall_i;
  end

  // ---------------- mask memory ----------------
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (state_q == S_STEP) rdata_q <= mem[rd_addr];
  end

  // ---------------- control ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:    if (clr_cnt_q == (ADDR_W+1)'(DEPTH - 1)) state_d = S_IDLE;
      S_IDLE:   if (in_acc && req_type_i) state_d = S_SQX;
      S_SQX:    state_d = S_SQY;
      S_SQY:    state_d = S_SQRT;
      S_SQRT:   if (cnt_q == 6'd1) state_d = S_PREPX;
      S_PREPX:  state_d = (ax_q == '0) ? S_PREPY : S_DIV;
      S_PREPY:  state_d = (ay_q == '0) ? S_FBX : S_DIV;
      S_DIV:    if (cnt_q == 6'd1) state_d = S_DIVEND;
      S_DIVEND: begin
        case (sel_q)
          DIV_STEP_X: state_d = S_PREPY;
          DIV_STEP_Y: state_d = S_FBX;
          DIV_HIT_X:  state_d = S_ALY;
          default:    state_d = S_DONE;
        endcase
      end
      S_FBX:    state_d = S_FBY;
      S_FBY:    state_d = (len_q == '0) ? S_DONE : S_STEP;
      S_STEP:   state_d = S_TEST;
      S_TEST: begin
        if (over_q) state_d = S_DONE;
        else if (ingrid_q && ((rdata_q & tmask_q) != '0)) state_d = S_ALX;
        else if (dist_q < {8'd0, len_q}) state_d = S_STEP;
        else state_d = S_DONE;
      end
      S_ALX:    state_d = S_DIV;
      S_ALY:    state_d = S_DIV;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      gw_q        <= GRID_W'(64);
      gh_q        <= GRID_W'(64);
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_cnt_q <= clr_cnt_q + 1'b1;

      if (cfg_valid_i) begin
        if (cfg_index_i == REG_GRID_WIDTH) gw_q <= cfg_data_i;
        else if (cfg_index_i == REG_GRID_HEIGHT) gh_q <= cfg_data_i;
      end

      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      case (state_q)
        S_SQY:   cnt_q <= 6'd24;
        S_PREPX: cnt_q <= 6'd32;
        S_PREPY: cnt_q <= 6'd32;
        S_ALX:   cnt_q <= 6'd49;
        S_ALY:   cnt_q <= 6'd49;
        S_SQRT:  cnt_q <= cnt_q - 1'b1;
        S_DIV:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc && req_type_i) begin
          sx_q    <= start_x_i;
          sy_q    <= start_y_i;
          tx_q    <= traj_x_i;
          ty_q    <= traj_y_i;
          ax_q    <= traj_x_i[15] ? 16'(-traj_x_i) : traj_x_i;
          ay_q    <= traj_y_i[15] ? 16'(-traj_y_i) : traj_y_i;
          tmask_q <= test_mask_i[MASK_BITS-1:0];
        end
      end
      S_SQX: begin
        acc_q  <= ax_q * ax_q;
        hx_q   <= sat16(18'(sx_q) + 18'(tx_q));
        hy_q   <= sat16(18'(sy_q) + 18'(ty_q));
        hit_q  <= 1'b0;
        vert_q <= 1'b0;
        cx_q   <= CELL_W'($signed(sx_q[15:8]));
        cy_q   <= CELL_W'($signed(sy_q[15:8]));
        dist_q <= '0;
        stx_q  <= DIST_MAX;
        sty_q  <= DIST_MAX;
      end
      S_SQY: begin
        rad_q  <= {acc_q + 32'(ay_q * ay_q), 16'd0};
        srem_q <= '0;
        len_q  <= '0;
      end
      S_SQRT: begin
        rad_q <= {rad_q[45:0], 2'b00};
        if (sq_sh >= sq_trial) begin
          srem_q <= sq_sh - sq_trial;
          len_q  <= {len_q[22:0], 1'b1};
        end else begin
          srem_q <= sq_sh;
          len_q  <= {len_q[22:0], 1'b0};
        end
      end
      S_PREPX: begin
        num_q  <= {len_q, 8'd0, 17'd0};
        dv_q   <= 24'(ax_q);
        drem_q <= '0;
        sel_q  <= DIV_STEP_X;
      end
      S_PREPY: begin
        num_q  <= {len_q, 8'd0, 17'd0};
        dv_q   <= 24'(ay_q);
        drem_q <= '0;
        sel_q  <= DIV_STEP_Y;
      end
      S_ALX, S_ALY: begin
        num_q  <= 49'(amag * dist_q) + 49'(len_q >> 1);
        dv_q   <= len_q;
        drem_q <= '0;
        sel_q  <= (state_q == S_ALX) ? DIV_HIT_X : DIV_HIT_Y;
      end
      S_DIV: begin
        num_q  <= {num_q[47:0], 1'b0};
        drem_q <= dv_ge ? 24'(dv_sh - {1'b0, dv_q}) : dv_sh[23:0];
        quo_q  <= {quo_q[30:0], dv_ge};
      end
      S_DIVEND: begin
        case (sel_q)
          DIV_STEP_X: stx_q <= quo_q;
          DIV_STEP_Y: sty_q <= quo_q;
          DIV_HIT_X:  hx_q  <= sat16(hsum);
          default: begin
            hy_q  <= sat16(hsum);
            hit_q <= 1'b1;
          end
        endcase
      end
      S_FBX: px_q <= fb_val;
      S_FBY: py_q <= fb_val;
      S_STEP: begin
        cx_q     <= nx;
        cy_q     <= ny;
        dist_q   <= nd;
        vert_q   <= !x_move;
        ingrid_q <= nin;
        over_q   <= nd > {8'd0, len_q};
        if (x_move) px_q <= adv_sum[32] ? DIST_MAX : adv_sum[31:0];
        else        py_q <= adv_sum[32] ? DIST_MAX : adv_sum[31:0];
      end
      S_DONE: begin
        if (out_free) begin
          res_hit_q  <= hit_q;
          res_x_q    <= hx_q;
          res_y_q    <= hy_q;
          res_vert_q <= vert_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for grid_ray_collision_search_unit
// uses grcs_pkg; holds its own ray walk predictor and mask store copy
module tb;
  import grcs_pkg::*;

  localparam int CLEAR_WAIT = 4200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic [5:0] cell_x_i = '0;
  logic [5:0] cell_y_i = '0;
  logic [7:0] cell_mask_i = '0;
  logic signed [15:0] start_x_i = '0;
  logic signed [15:0] start_y_i = '0;
  logic signed [15:0] traj_x_i = '0;
  logic signed [15:0] traj_y_i = '0;
  logic [7:0] test_mask_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic signed [15:0] hit_x_o;
  logic signed [15:0] hit_y_o;
  logic vertical_hit_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [GRID_W-1:0] cfg_data_i = '0;

  typedef struct packed {
    logic hit;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    logic vert;
  } ray_res_t;

  ray_res_t ray_q[$];
  mask_t cell_masks[DEPTH];
  int unsigned cols_used = 64;
  int unsigned rows_used = 64;
  int mismatches = 0;

  grid_ray_collision_search_unit i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] clip_dist(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] point_on(input int s, input int c,
                                                  input logic [63:0] d,
                                                  input logic [63:0] l);
    logic [63:0] m, q;
    m = (c < 0) ? -c : c;
    q = (m * d + l / 2) / l;
    return clip16(longint'(s) + ((c < 0) ? -longint'(q) : longint'(q)));
  endfunction

  // dda walk over the copied mask store
  function automatic ray_res_t walk_ray(input int sx, input int sy, input int tx,
                                        input int ty, input mask_t tm);
    ray_res_t r;
    logic [63:0] l, stx, sty, px, py, d, mx, my;
    int cx, cy, dx, dy, gw, gh;
    gw = (cols_used < 64) ? cols_used : 64;
    gh = (rows_used < 64) ? rows_used : 64;
    l = root64((longint'(tx) * tx + longint'(ty) * ty) << 16);
    mx = (tx < 0) ? -tx : tx;
    my = (ty < 0) ? -ty : ty;
    stx = (mx == 0) ? 64'hFFFF_FFFF : clip_dist((l << 8) / mx);
    sty = (my == 0) ? 64'hFFFF_FFFF : clip_dist((l << 8) / my);
    px = (tx == 0) ? 64'hFFFF_FFFF : clip_dist(((tx < 0) ? (sx & 255) :
         (256 - (sx & 255))) * stx >> 8);
    py = (ty == 0) ? 64'hFFFF_FFFF : clip_dist(((ty < 0) ? (sy & 255) :
         (256 - (sy & 255))) * sty >> 8);
    dx = (tx < 0) ? -1 : 1;
    dy = (ty < 0) ? -1 : 1;
    cx = sx >>> 8;
    cy = sy >>> 8;
    r.hit = 1'b0;
    r.hx = clip16(sx + tx);
    r.hy = clip16(sy + ty);
    r.vert = 1'b0;
    d = 0;
    while (d < l) begin
      if (px < py) begin
        cx += dx; d = px; px = clip_dist(px + stx); r.vert = 1'b0;
      end else begin
        cy += dy; d = py; py = clip_dist(py + sty); r.vert = 1'b1;
      end
      if (d > l) break;
      if (cx >= 0 && cx < gw && cy >= 0 && cy < gh &&
          (cell_masks[cy * 64 + cx] & tm) != 0) begin
        r.hit = 1'b1;
        r.hx = point_on(sx, tx, d, l);
        r.hy = point_on(sy, ty, d, l);
        break;
      end
    end
    return r;
  endfunction

  // called at a falling edge; valid stays high after the transfer so that
  // a following item can come with no gap, drain or the end drops it
  task automatic send_item(input bit rt, input int x, input int y, input int m,
                           input int sx, input int sy, input int tx, input int ty,
                           input int tm);
    int gap;
    gap = $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i <= rt; cell_x_i <= 6'(x); cell_y_i <= 6'(y); cell_mask_i <= 8'(m);
    start_x_i <= 16'(sx); start_y_i <= 16'(sy); traj_x_i <= 16'(tx);
    traj_y_i <= 16'(ty);
    test_mask_i <= 8'(tm);
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!rt) cell_masks[y * 64 + x] = mask_t'(m);
    else ray_q.push_back(walk_ray(int'($signed(16'(sx))),
                                  int'($signed(16'(sy))), int'($signed(16'(tx))),
                                  int'($signed(16'(ty))), mask_t'(tm)));
    @(negedge clk_i);
  endtask

  task automatic trace(input int sx, input int sy, input int tx, input int ty,
                       input int tm);
    send_item(1'b1, 0, 0, 0, sx, sy, tx, ty, tm);
  endtask

  task automatic put_cell(input int x, input int y, input int m);
    send_item(1'b0, x, y, m, 0, 0, 0, 0, 0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (ray_q.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
    @(negedge clk_i);
    cfg_index_i <= idx; cfg_data_i <= GRID_W'(v); cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_GRID_WIDTH) cols_used = v;
    else if (idx == REG_GRID_HEIGHT) rows_used = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    ray_res_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ray_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        exp_r = ray_q.pop_front();
        if (exp_r !== {hit_o, hit_x_o, hit_y_o, vertical_hit_o}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp hit %0d x %0d y %0d v %0d got %0d %0d %0d %0d",
                     exp_r.hit, exp_r.hx, exp_r.hy, exp_r.vert,
                     hit_o, hit_x_o, hit_y_o, vertical_hit_o);
        end
      end
    end
  end

  // receiver holds each waiting result for a random number of cycles
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (out_valid_o) begin
        gap = $urandom_range(0, 19);
        if (gap != 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic test_directed();
    put_cell(5, 5, 8'hFF);
    put_cell(0, 0, 8'h01);
    put_cell(63, 63, 8'h80);
    put_cell(10, 5, 8'h10);
    trace(16'h0080, 16'h0580, 16'h0A00, 0, 8'hFF);
    trace(16'h0580, 16'h0080, 0, 16'h0A00, 8'hFF);
    trace(16'h0580, 16'h0580, 0, 0, 8'hFF);
    trace(16'h3E80, 16'h3E80, 16'h0400, 16'h0400, 8'h80);
    trace(16'h0580, 16'h0580, 16'h7FFF, 16'h7FFF, 8'h01);
    trace(16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'hFF);
    trace(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'hFF);
    trace(16'h0C00, 16'h0580, 16'hF800, 0, 8'h10);
    trace(16'h0180, 16'h0180, 16'hFE80, 16'hFE80, 8'hFF);
    trace(16'h0000, 16'h0500, 16'h0A00, 16'h0000, 8'h10);
    trace(16'h0300, 16'h0300, 16'h0200, 16'h0200, 8'hFF);
    trace(16'h0580, 16'h0580, 16'h0100, 0, 8'h00);
    put_cell(5, 5, 8'h00);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0)
        put_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
      else if ($urandom_range(0, 9) == 0)
        trace($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 255));
      else
        trace($urandom_range(0, 16383), $urandom_range(0, 16383),
              int'($signed(16'($urandom_range(0, 8191)))) - 4096,
              int'($signed(16'($urandom_range(0, 8191)))) - 4096,
              $urandom_range(0, 255));
    end
  endtask

  task automatic test_grid_regs();
    drain();
    write_reg(REG_GRID_WIDTH, 1); write_reg(REG_GRID_HEIGHT, 1);
    test_random(60);
    drain();
    write_reg(REG_GRID_WIDTH, 0); write_reg(REG_GRID_HEIGHT, 127);
    test_random(40);
    drain();
    write_reg(REG_GRID_WIDTH, 20); write_reg(REG_GRID_HEIGHT, 33);
    write_reg(CFG_IDX_W'(5), 3);
    test_random(80);
    drain();
    write_reg(REG_GRID_WIDTH, 64); write_reg(REG_GRID_HEIGHT, 64);
  endtask

  initial begin
    foreach (cell_masks[i]) cell_masks[i] = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (CLEAR_WAIT) @(negedge clk_i);
    test_directed();
    test_random(150);
    test_grid_regs();
    test_random(170);
    in_valid_i <= 1'b0;
    while (ray_q.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    if (mismatches == 0 && ray_q.size() == 0) begin
      $display("PASS grid_ray_collision_search_unit");
    end else begin
      $display("FAIL grid_ray_collision_search_unit");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL grid_ray_collision_search_unit");
    $finish;
  end
endmodule
